// ===== rtl/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16LE to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            eos;
		logic            err;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/u16u8_front.sv =====
// Front end: accepts code units, pairs surrogates and encodes code points into byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             unit_valid,
	output logic                  unit_ready,
	input  wire logic [15:0]      code_unit,
	input  wire logic             last_unit,
	input  wire logic             q_full,
	output logic                  q_push,
	output u16u8_pkg::job_t       q_data
);
	import u16u8_pkg::*;

	logic [9:0]  held_q;
	logic        pending_q;
	logic        accept;
	logic        is_high;
	logic [20:0] cp;
	logic [2:0]  n;
	logic [3:0][7:0] b;

	assign unit_ready = !q_full;
	assign accept     = unit_valid && unit_ready;
	assign is_high    = (code_unit[15:10] == SURR_HIGH_TAG);

	always_comb begin
		if (pending_q) begin
			cp = {1'b0, held_q, code_unit[9:0]} + SUPP_BASE;
		end else begin
			cp = {5'b0, code_unit};
		end
	end

	always_comb begin
		b = '0;
		n = 3'd0;
		priority if (cp == 21'd0) begin
			n = 3'd0;
		end else if (cp < 21'h80) begin
			n    = 3'd1;
			b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			n    = 3'd2;
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			n    = 3'd3;
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
		end else begin
			n    = 3'd4;
			b[0] = {5'b11110, cp[20:18]};
			b[1] = {2'b10, cp[17:12]};
			b[2] = {2'b10, cp[11:6]};
			b[3] = {2'b10, cp[5:0]};
		end
	end

	always_comb begin
		q_push = 1'b0;
		q_data = '{bytes: b, count: n, eos: last_unit, err: 1'b0};
		if (!pending_q && is_high) begin
			q_data = '{bytes: '0, count: 3'd0, eos: 1'b1, err: 1'b1};
			q_push = accept && last_unit;
		end else begin
			q_push = accept && ((n != 3'd0) || last_unit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
		end else if (accept) begin
			if (!pending_q && is_high && !last_unit) begin
				pending_q <= 1'b1;
				held_q    <= code_unit[9:0];
			end else begin
				pending_q <= 1'b0;
				held_q    <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u16u8_queue.sv =====
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u16u8_pkg::job_t  wdata,
	output logic                  full,
	input  wire logic             pop,
	output u16u8_pkg::job_t       rdata,
	output logic                  empty
);
	import u16u8_pkg::*;

	job_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == Q_CW'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u16u8_back.sv =====
// Back end: walks the head job byte by byte into the output register.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire u16u8_pkg::job_t  head,
	input  wire logic             q_empty,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  byte_valid,
	output logic                  end_of_stream,
	output logic                  error
);
	import u16u8_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       bval_q;
	logic       eos_q;
	logic       err_q;
	logic       load;
	logic       last_byte;

	assign load      = !q_empty && (!valid_q || out_ready);
	assign last_byte = (head.count == 3'd0) || (({1'b0, idx_q} + 3'd1) == head.count);
	assign q_pop     = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			bval_q <= (head.count != 3'd0);
			eos_q  <= head.eos && last_byte;
			err_q  <= head.err;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign byte_valid    = bval_q;
	assign end_of_stream = eos_q;
	assign error         = err_q;

endmodule
`default_nettype wire

// ===== rtl/utf16le_to_utf8_transcoder.sv =====
// Top level of the UTF-16LE to UTF-8 transcoder.
// One UTF-16 code unit enters per item and UTF-8 bytes leave one per cycle, while the sink is
// ready, from a registered output: a unit yields as many bytes as its character needs (1 to 3
// for a BMP character, 3 for most text above U+07FF, 4 for a surrogate pair spread over its two
// units), and the output register's one-byte-per-cycle drain while the sink is ready sets the
// sustained rate. A held high surrogate yields nothing until its partner arrives; a zero unit
// yields nothing unless it is last, when a bare end marker (no valid byte) closes the string. A
// string ending on a high surrogate closes with a marker flagged as an error. A four-entry job
// queue lets the input keep accepting while earlier bytes drain.
`timescale 1ns / 1ps
`default_nettype none
module utf16le_to_utf8_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] code_unit
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]       m_axis_tuser,  // [0] byte_valid, [1] error
	output logic             m_axis_tlast
);
	import u16u8_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (s_axis_tvalid),
		.unit_ready (s_axis_tready),
		.code_unit  (s_axis_tdata),
		.last_unit  (s_axis_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	u16u8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_rdata),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.byte_valid    (m_axis_tuser[0]),
		.end_of_stream (m_axis_tlast),
		.error         (m_axis_tuser[1])
	);

	a_err_is_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("error item is not a bare end marker");

	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("item without valid byte is not a zero end marker");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("job written into full queue");

endmodule
`default_nettype wire
